@@ rtl/sms_pkg.sv @@
// shared types and constants for the data stack alu
package sms_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CELL_W      = 64;

    typedef enum logic [4:0] {
        FN_PUSH   = 5'd0,
        FN_ADD    = 5'd1,
        FN_SUB    = 5'd2,
        FN_MUL    = 5'd3,
        FN_DIV    = 5'd4,
        FN_MOD    = 5'd5,
        FN_DUP    = 5'd6,
        FN_DROP   = 5'd7,
        FN_SWAP   = 5'd8,
        FN_OVER   = 5'd9,
        FN_ROT    = 5'd10,
        FN_PRINT  = 5'd11,
        FN_DUMP   = 5'd12,
        FN_EMIT   = 5'd13,
        FN_DEPTH  = 5'd14,
        FN_EQ     = 5'd15,
        FN_LT     = 5'd16,
        FN_GT     = 5'd17,
        FN_ZEQ    = 5'd18,
        FN_AND    = 5'd19,
        FN_OR     = 5'd20,
        FN_XOR    = 5'd21,
        FN_INVERT = 5'd22
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PK_NONE  = 2'd0,
        PK_NUM   = 2'd1,
        PK_CHAR  = 2'd2,
        PK_DUMP  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_UP   = 2'd1,
        CELL_DOWN = 2'd2
    } cell_op_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUSH,
        CMD_POP,
        CMD_SET_TOP,
        CMD_SWAP,
        CMD_ROT,
        CMD_ROTDN
    } stack_cmd_t;

    typedef enum logic [1:0] {
        AOP_MUL,
        AOP_DIV,
        AOP_MOD
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_RUN,
        AS_FIX,
        AS_DONE
    } alu_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIN,
        S_WAIT,
        S_RESP,
        S_DUMP
    } state_t;

endpackage

@@ rtl/stack_machine_data_stack_alu_unit.sv @@
// forth data stack with alu: top level, sequencer and row of stack cells
//
// in channel: in_valid/in_ready with func and literal, one primitive per beat.
// out channel: out_valid/out_ready with status, print_kind, shown_value,
// depth_after and last; every input beat yields one output beat, except a
// dump of a non-empty stack, which yields one beat per entry, bottom first,
// with last on the final one.
// the stack is a row of 64 cells with the top in cell 0; each cycle every
// cell keeps its value or takes that of a neighbor or, in cell 0, a new one.
// sequence: most primitives execute, then load the output register; add,
// sub, compare and logic ops, and a division by zero, pass through the
// binary state in between; mul, div and mod then wait for the
// one-bit-per-cycle shift-add / restoring divide unit. a dump emits one beat
// per entry, the stack rotating by one cell per beat.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next beat may be accepted while it waits.
// a stalled receiver holds the sequencer in its output state.
// reset clears the depth and the control state; cell contents are not reset.
module stack_machine_data_stack_alu_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  func,
    input  logic signed [63:0] literal,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [1:0]  print_kind,
    output logic signed [63:0] shown_value,
    output logic [6:0]  depth_after,
    output logic        last
);

    localparam int N  = sms_pkg::STACK_DEPTH;
    localparam int W  = sms_pkg::CELL_W;
    localparam int DW = sms_pkg::DEPTH_W;
    localparam int IW = sms_pkg::IDX_W;

    logic [W-1:0]        cell_q [N];
    sms_pkg::cell_op_t   cell_op [N];
    sms_pkg::stack_cmd_t cmd;
    logic [W-1:0]        bcast;
    logic [W-1:0]        bottom;
    logic [IW-1:0]       bot_idx;

    sms_pkg::state_t     state_reg, state_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [4:0]          func_reg, func_next;
    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        b_reg, b_next;
    logic [1:0]          st_reg, st_next;
    logic [1:0]          kind_reg, kind_next;
    logic [W-1:0]        shown_reg, shown_next;
    logic                has_shown_reg, has_shown_next;
    logic [IW-1:0]       cnt_reg, cnt_next;

    logic                ovalid_reg, ovalid_next;
    logic [1:0]          ostat_reg, ostat_next;
    logic [1:0]          okind_reg, okind_next;
    logic [W-1:0]        oval_reg, oval_next;
    logic [DW-1:0]       odepth_reg, odepth_next;
    logic                olast_reg, olast_next;

    sms_pkg::alu_req_t   alu_req;
    logic                alu_done;
    logic [W-1:0]        alu_result;
    logic                out_free;
    logic [W-1:0]        top_or_zero;
    logic [W-1:0]        bin_r;

    // row of cells, top in cell 0
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [W-1:0] up_in;
        logic [W-1:0] down_in;

        if (i == 0)
        begin : g_head
            assign up_in = bcast;
        end
        else
        begin : g_body
            assign up_in = cell_q[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign down_in = '0;
        end
        else
        begin : g_inner
            assign down_in = cell_q[i+1];
        end

        always_comb
        begin
            case (cmd)
                sms_pkg::CMD_PUSH:    cell_op[i] = sms_pkg::CELL_UP;
                sms_pkg::CMD_POP:     cell_op[i] = sms_pkg::CELL_DOWN;
                sms_pkg::CMD_SET_TOP: cell_op[i] = (i == 0) ? sms_pkg::CELL_UP
                                                            : sms_pkg::CELL_HOLD;
                sms_pkg::CMD_SWAP:    cell_op[i] = (i == 0) ? sms_pkg::CELL_DOWN :
                                                   (i == 1) ? sms_pkg::CELL_UP
                                                            : sms_pkg::CELL_HOLD;
                sms_pkg::CMD_ROT:     cell_op[i] = (i <= 2) ? sms_pkg::CELL_UP
                                                            : sms_pkg::CELL_HOLD;
                sms_pkg::CMD_ROTDN:   cell_op[i] = (DW'(i) < depth_reg) ? sms_pkg::CELL_UP
                                                                        : sms_pkg::CELL_HOLD;
                default:              cell_op[i] = sms_pkg::CELL_HOLD;
            endcase
        end

        sms_cell u_cell (
            .clk     (clk),
            .op      (cell_op[i]),
            .up_in   (up_in),
            .down_in (down_in),
            .val     (cell_q[i])
        );
    end

    // bottom entry of the used part, fed back to the top during a dump
    assign bot_idx = IW'(depth_reg - 1'b1);

    always_comb
    begin
        bottom = '0;
        for (int k = 0; k < N; k++)
        begin
            if (bot_idx == IW'(k))
            begin
                bottom = bottom | cell_q[k];
            end
        end
    end

    sms_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (a_reg),
        .b      (b_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sms_pkg::S_IDLE;
            depth_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        st_reg        <= st_next;
        kind_reg      <= kind_next;
        shown_reg     <= shown_next;
        has_shown_reg <= has_shown_next;
        cnt_reg       <= cnt_next;
        ostat_reg     <= ostat_next;
        okind_reg     <= okind_next;
        oval_reg      <= oval_next;
        odepth_reg    <= odepth_next;
        olast_reg     <= olast_next;
    end

    assign out_free    = !ovalid_reg || out_ready;
    assign top_or_zero = (depth_reg != '0) ? cell_q[0] : '0;

    always_comb
    begin
        case (func_reg)
            sms_pkg::FN_ADD: bin_r = a_reg + b_reg;
            sms_pkg::FN_SUB: bin_r = a_reg - b_reg;
            sms_pkg::FN_EQ:  bin_r = {W{a_reg == b_reg}};
            sms_pkg::FN_LT:  bin_r = {W{$signed(a_reg) < $signed(b_reg)}};
            sms_pkg::FN_GT:  bin_r = {W{$signed(b_reg) < $signed(a_reg)}};
            sms_pkg::FN_AND: bin_r = a_reg & b_reg;
            sms_pkg::FN_OR:  bin_r = a_reg | b_reg;
            default:         bin_r = a_reg ^ b_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        st_next        = st_reg;
        kind_next      = kind_reg;
        shown_next     = shown_reg;
        has_shown_next = has_shown_reg;
        cnt_next       = cnt_reg;
        ovalid_next    = ovalid_reg && !out_ready;
        ostat_next     = ostat_reg;
        okind_next     = okind_reg;
        oval_next      = oval_reg;
        odepth_next    = odepth_reg;
        olast_next     = olast_reg;
        cmd            = sms_pkg::CMD_NONE;
        bcast          = '0;
        alu_req.start  = 1'b0;
        alu_req.op     = sms_pkg::AOP_MUL;
        in_ready       = 1'b0;

        unique case (state_reg)
            sms_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next      = func;
                    st_next        = sms_pkg::ST_OK;
                    kind_next      = sms_pkg::PK_NONE;
                    has_shown_next = 1'b0;
                    state_next     = sms_pkg::S_RESP;
                    case (func)
                        sms_pkg::FN_PUSH, sms_pkg::FN_DEPTH:
                        begin
                            if (depth_reg == DW'(N))
                            begin
                                st_next = sms_pkg::ST_OVER;
                            end
                            else
                            begin
                                cmd        = sms_pkg::CMD_PUSH;
                                bcast      = (func == sms_pkg::FN_PUSH) ? literal
                                                                        : W'(depth_reg);
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        sms_pkg::FN_ADD, sms_pkg::FN_SUB, sms_pkg::FN_MUL,
                        sms_pkg::FN_DIV, sms_pkg::FN_MOD, sms_pkg::FN_EQ,
                        sms_pkg::FN_LT, sms_pkg::FN_GT, sms_pkg::FN_AND,
                        sms_pkg::FN_OR, sms_pkg::FN_XOR:
                        begin
                            if (depth_reg == '0)
                            begin
                                st_next = sms_pkg::ST_UNDER;
                            end
                            else
                            begin
                                // b goes first, even when a is missing
                                b_next     = cell_q[0];
                                a_next     = cell_q[1];
                                cmd        = sms_pkg::CMD_POP;
                                depth_next = depth_reg - 1'b1;
                                if (depth_reg == DW'(1))
                                begin
                                    st_next = sms_pkg::ST_UNDER;
                                end
                                else
                                begin
                                    state_next = sms_pkg::S_BIN;
                                end
                            end
                        end
                        sms_pkg::FN_DUP, sms_pkg::FN_OVER:
                        begin
                            if (depth_reg < ((func == sms_pkg::FN_DUP) ? DW'(1) : DW'(2)))
                            begin
                                st_next = sms_pkg::ST_UNDER;
                            end
                            else if (depth_reg == DW'(N))
                            begin
                                st_next = sms_pkg::ST_OVER;
                            end
                            else
                            begin
                                cmd        = sms_pkg::CMD_PUSH;
                                bcast      = (func == sms_pkg::FN_DUP) ? cell_q[0] : cell_q[1];
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        sms_pkg::FN_DROP, sms_pkg::FN_PRINT, sms_pkg::FN_EMIT:
                        begin
                            if (depth_reg == '0)
                            begin
                                st_next = sms_pkg::ST_UNDER;
                            end
                            else
                            begin
                                cmd        = sms_pkg::CMD_POP;
                                depth_next = depth_reg - 1'b1;
                                if (func == sms_pkg::FN_PRINT)
                                begin
                                    kind_next      = sms_pkg::PK_NUM;
                                    shown_next     = cell_q[0];
                                    has_shown_next = 1'b1;
                                end
                                else if (func == sms_pkg::FN_EMIT)
                                begin
                                    kind_next      = sms_pkg::PK_CHAR;
                                    shown_next     = {{(W-8){1'b0}}, cell_q[0][7:0]};
                                    has_shown_next = 1'b1;
                                end
                            end
                        end
                        sms_pkg::FN_ZEQ, sms_pkg::FN_INVERT:
                        begin
                            if (depth_reg == '0)
                            begin
                                st_next = sms_pkg::ST_UNDER;
                            end
                            else
                            begin
                                cmd   = sms_pkg::CMD_SET_TOP;
                                bcast = (func == sms_pkg::FN_ZEQ) ? {W{cell_q[0] == '0}}
                                                                  : ~cell_q[0];
                            end
                        end
                        sms_pkg::FN_SWAP:
                        begin
                            if (depth_reg < DW'(2))
                            begin
                                st_next = sms_pkg::ST_UNDER;
                            end
                            else
                            begin
                                cmd = sms_pkg::CMD_SWAP;
                            end
                        end
                        sms_pkg::FN_ROT:
                        begin
                            if (depth_reg < DW'(3))
                            begin
                                st_next = sms_pkg::ST_UNDER;
                            end
                            else
                            begin
                                cmd   = sms_pkg::CMD_ROT;
                                bcast = cell_q[2];
                            end
                        end
                        sms_pkg::FN_DUMP:
                        begin
                            if (depth_reg != '0)
                            begin
                                cnt_next   = '0;
                                state_next = sms_pkg::S_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sms_pkg::S_BIN:
            begin
                // top now holds a; replace it with the result, or pop it on a division by zero
                if (func_reg == sms_pkg::FN_MUL)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = sms_pkg::AOP_MUL;
                    state_next    = sms_pkg::S_WAIT;
                end
                else if (func_reg == sms_pkg::FN_DIV || func_reg == sms_pkg::FN_MOD)
                begin
                    if (b_reg == '0)
                    begin
                        cmd        = sms_pkg::CMD_POP;
                        depth_next = depth_reg - 1'b1;
                        st_next    = sms_pkg::ST_DIVZ;
                        state_next = sms_pkg::S_RESP;
                    end
                    else
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = (func_reg == sms_pkg::FN_DIV) ? sms_pkg::AOP_DIV
                                                                      : sms_pkg::AOP_MOD;
                        state_next    = sms_pkg::S_WAIT;
                    end
                end
                else
                begin
                    cmd        = sms_pkg::CMD_SET_TOP;
                    bcast      = bin_r;
                    state_next = sms_pkg::S_RESP;
                end
            end
            sms_pkg::S_WAIT:
            begin
                if (alu_done)
                begin
                    cmd        = sms_pkg::CMD_SET_TOP;
                    bcast      = alu_result;
                    state_next = sms_pkg::S_RESP;
                end
            end
            sms_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = st_reg;
                    okind_next  = kind_reg;
                    oval_next   = has_shown_reg ? shown_reg : top_or_zero;
                    odepth_next = depth_reg;
                    olast_next  = 1'b1;
                    state_next  = sms_pkg::S_IDLE;
                end
            end
            sms_pkg::S_DUMP:
            begin
                if (out_free)
                begin
                    // one beat per entry, the used part rotating down by one
                    ovalid_next = 1'b1;
                    ostat_next  = sms_pkg::ST_OK;
                    okind_next  = sms_pkg::PK_DUMP;
                    oval_next   = bottom;
                    odepth_next = depth_reg;
                    olast_next  = (cnt_reg == bot_idx);
                    cmd         = sms_pkg::CMD_ROTDN;
                    bcast       = bottom;
                    cnt_next    = cnt_reg + 1'b1;
                    if (cnt_reg == bot_idx)
                    begin
                        state_next = sms_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sms_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid   = ovalid_reg;
    assign status      = ostat_reg;
    assign print_kind  = okind_reg;
    assign shown_value = oval_reg;
    assign depth_after = odepth_reg;
    assign last        = olast_reg;

endmodule

@@ rtl/sms_cell.sv @@
// one stack entry: holds, takes its upper neighbor or its lower neighbor
module sms_cell (
    input  logic                     clk,
    input  sms_pkg::cell_op_t        op,
    input  logic [sms_pkg::CELL_W-1:0] up_in,
    input  logic [sms_pkg::CELL_W-1:0] down_in,
    output logic [sms_pkg::CELL_W-1:0] val
);

    logic [sms_pkg::CELL_W-1:0] val_reg;
    logic [sms_pkg::CELL_W-1:0] val_next;

    always_comb
    begin
        case (op)
            sms_pkg::CELL_UP:   val_next = up_in;
            sms_pkg::CELL_DOWN: val_next = down_in;
            default:            val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

@@ rtl/sms_alu.sv @@
// iterative multiplier and signed divider, one bit per cycle
module sms_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sms_pkg::alu_req_t          req,
    input  logic [sms_pkg::CELL_W-1:0] a,
    input  logic [sms_pkg::CELL_W-1:0] b,
    output logic                       done,
    output logic [sms_pkg::CELL_W-1:0] result
);

    localparam int W = sms_pkg::CELL_W;

    sms_pkg::alu_state_t state_reg, state_next;
    sms_pkg::alu_op_t    op_reg, op_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        x_reg, x_next;
    logic [W-1:0]        y_reg, y_next;
    logic [$clog2(W)-1:0] cnt_reg, cnt_next;
    logic                negq_reg, negq_next;
    logic                negr_reg, negr_next;
    logic [W-1:0]        res_reg, res_next;
    logic [W:0]          trial;
    logic [W:0]          diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sms_pkg::AS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        cnt_reg  <= cnt_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        negq_next  = negq_reg;
        negr_next  = negr_reg;
        res_next   = res_reg;
        trial      = {acc_reg, x_reg[W-1]};
        diff       = trial - {1'b0, y_reg};
        unique case (state_reg)
            sms_pkg::AS_IDLE:
            begin
                if (req.start)
                begin
                    op_next   = req.op;
                    acc_next  = '0;
                    cnt_next  = '0;
                    negq_next = a[W-1] ^ b[W-1];
                    negr_next = a[W-1];
                    if (req.op == sms_pkg::AOP_MUL)
                    begin
                        x_next = a;
                        y_next = b;
                    end
                    else
                    begin
                        x_next = a[W-1] ? (~a + 1'b1) : a;
                        y_next = b[W-1] ? (~b + 1'b1) : b;
                    end
                    state_next = sms_pkg::AS_RUN;
                end
            end
            sms_pkg::AS_RUN:
            begin
                if (op_reg == sms_pkg::AOP_MUL)
                begin
                    if (y_reg[0])
                    begin
                        acc_next = acc_reg + x_reg;
                    end
                    x_next = {x_reg[W-2:0], 1'b0};
                    y_next = {1'b0, y_reg[W-1:1]};
                end
                else
                begin
                    // restoring step: remainder stays below the divisor
                    if (!diff[W])
                    begin
                        acc_next = diff[W-1:0];
                        x_next   = {x_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = trial[W-1:0];
                        x_next   = {x_reg[W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == $clog2(W)'(W - 1))
                begin
                    state_next = sms_pkg::AS_FIX;
                end
            end
            sms_pkg::AS_FIX:
            begin
                case (op_reg)
                    sms_pkg::AOP_MUL: res_next = acc_reg;
                    sms_pkg::AOP_DIV: res_next = negq_reg ? (~x_reg + 1'b1) : x_reg;
                    default:          res_next = negr_reg ? (~acc_reg + 1'b1) : acc_reg;
                endcase
                state_next = sms_pkg::AS_DONE;
            end
            sms_pkg::AS_DONE:
            begin
                state_next = sms_pkg::AS_IDLE;
            end
            default:
            begin
                state_next = sms_pkg::AS_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == sms_pkg::AS_DONE);
    assign result = res_reg;

endmodule
